/* hw/rtl/kmdr_pkg.sv */
// Shared types and constants for the key matrix scanner.
// Used by every module of the block; depends on nothing else.
`default_nettype none

package kmdr_pkg;

  // Fixed field widths
  localparam int COL_W    = 3;
  localparam int ROW_W    = 6;
  localparam int ROW_IW   = 3;
  localparam int KEY_W    = 6;
  localparam int CODE_W   = 8;
  localparam int TIMER_W  = 8;
  localparam int NUM_SLOTS = 6;
  localparam int REP_W    = NUM_SLOTS * CODE_W + CODE_W;
  localparam int IN_W     = COL_W + ROW_W + KEY_W + CODE_W + 1;

  // Release timer codes
  localparam logic [TIMER_W-1:0] TIMER_ARM  = 8'h80;
  localparam logic [TIMER_W-1:0] TIMER_FIRE = 8'h01;

  // Command queue between front and back
  localparam int CMDQ_DEPTH = 2;
  localparam int CMDQ_AW    = 1;

  typedef enum logic [1:0] {
    FN_SCAN = 2'd0,
    FN_TICK = 2'd1,
    FN_MAP  = 2'd2
  } func_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EXEC,
    ST_FLUSH
  } seq_state_t;

  typedef struct packed {
    func_t              kind;
    logic [COL_W-1:0]   column;
    logic [ROW_W-1:0]   rows;
    logic [KEY_W-1:0]   key_index;
    logic [CODE_W-1:0]  usage_code;
    logic               is_mod;
  } cmd_t;

  typedef struct packed {
    logic              vld;
    logic [KEY_W-1:0]  idx;
    logic [CODE_W-1:0] code;
  } slot_t;

  typedef struct packed {
    logic             push;
    logic             last;
    logic [REP_W-1:0] data;
  } rep_push_t;

endpackage

`default_nettype wire

/* hw/rtl/kmdr_front.sv */
// Front end: accepts input items, decodes the kind and drops items that do nothing.
// Depends on kmdr_pkg; feeds kmdr_cmd_fifo.
`default_nettype none

module kmdr_front
  import kmdr_pkg::*;
#(
  parameter int NUM_COLS = 8,
  parameter int NUM_KEYS = 48
) (
  input  wire logic            s_axis_tvalid,
  output logic                 s_axis_tready,
  input  wire logic [IN_W-1:0] s_axis_tdata,  // column, rows, key_index, usage_code, is_mod
  input  wire logic [1:0]      s_axis_tuser,  // func
  input  wire logic            fifo_full,
  output logic                 push,
  output cmd_t                 cmd
);

  logic useful;

  // Unpack the item
  always_comb begin
    cmd.kind       = func_t'(s_axis_tuser);
    cmd.column     = s_axis_tdata[COL_W-1:0];
    cmd.rows       = s_axis_tdata[COL_W +: ROW_W];
    cmd.key_index  = s_axis_tdata[COL_W+ROW_W +: KEY_W];
    cmd.usage_code = s_axis_tdata[COL_W+ROW_W+KEY_W +: CODE_W];
    cmd.is_mod     = s_axis_tdata[IN_W-1];
  end

  // Drop out-of-range scans and writes, and unused codes
  always_comb begin
    case (cmd.kind)
      FN_SCAN: useful = int'(cmd.column) < NUM_COLS;
      FN_TICK: useful = 1'b1;
      FN_MAP:  useful = int'(cmd.key_index) < NUM_KEYS;
      default: useful = 1'b0;
    endcase
  end

  assign s_axis_tready = !fifo_full;
  assign push          = s_axis_tvalid && !fifo_full && useful;

endmodule

`default_nettype wire

/* hw/rtl/kmdr_cmd_fifo.sv */
// Two-entry command queue between the front end and the sequencer.
// Depends on kmdr_pkg.
`default_nettype none

module kmdr_cmd_fifo
  import kmdr_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic push,
  input  wire cmd_t din,
  output logic      full,
  output logic      valid,
  output cmd_t      head,
  input  wire logic pop
);

  cmd_t                 mem [CMDQ_DEPTH];
  logic [CMDQ_AW-1:0]   wptr;
  logic [CMDQ_AW-1:0]   rptr;
  logic [CMDQ_AW:0]     count;

  assign full  = count == (CMDQ_AW+1)'(CMDQ_DEPTH);
  assign valid = count != '0;
  assign head  = mem[rptr];

  // Store commands
  always_ff @(posedge clk) begin
    if (push) begin
      mem[wptr] <= din;
    end
  end

  // Advance pointers
  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (push) begin
        wptr <= wptr + 1'b1;
      end
      if (pop) begin
        rptr <= rptr + 1'b1;
      end
      case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

`default_nettype wire

/* hw/rtl/kmdr_exec.sv */
// Sequencer: walks the rows of a scan or the keys of a tick, keeps key state,
// the rollover queue and modifiers, and hands reports to the output stage.
// Depends on kmdr_pkg.
`default_nettype none

module kmdr_exec
  import kmdr_pkg::*;
#(
  parameter int NUM_COLS    = 8,
  parameter int NUM_ROWS    = 6,
  parameter int NUM_KEYS    = 48,
  parameter int QUEUE_DEPTH = 6
) (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic cmd_valid,
  input  wire cmd_t cmd,
  output logic      cmd_pop,
  input  wire logic out_ready,
  output rep_push_t rep
);

  localparam int KAW = (NUM_KEYS > 1) ? $clog2(NUM_KEYS) : 1;
  localparam int CAW = (NUM_COLS > 1) ? $clog2(NUM_COLS) : 1;

  seq_state_t state, state_next;
  func_t               kind;
  logic [ROW_W-1:0]    cur;
  logic [ROW_W-1:0]    change;
  logic [KEY_W-1:0]    k, k_next;
  logic [ROW_IW-1:0]   r, r_next;
  logic [ROW_W-1:0]    prev [NUM_COLS];
  slot_t               queue [QUEUE_DEPTH];
  slot_t               q_upd [QUEUE_DEPTH];
  slot_t               q_ext [QUEUE_DEPTH+1];
  logic [CODE_W-1:0]   mods, mods_upd;
  logic                pvalid;
  logic [REP_W-1:0]    pdata;

  // Keymap and key state memories
  logic [CODE_W:0]     kmem [NUM_KEYS];
  logic [TIMER_W:0]    tmem [NUM_KEYS];
  logic [NUM_KEYS-1:0] tvld;
  logic [CODE_W:0]     km_q;
  logic [TIMER_W:0]    tm_q;
  logic                tv_q;

  logic               ent_held;
  logic [TIMER_W-1:0] ent_timer;
  logic               in_range;
  logic               act, press, expire, emit, go, last_step;
  logic [TIMER_W:0]   wdata;
  logic               key_is_mod;
  logic [CODE_W-1:0]  key_code;
  logic               found;
  logic [CODE_W-1:0]  rep_keys [NUM_SLOTS];
  logic [REP_W-1:0]   rep_word;

  // Entry read back from memory; never-written entries read as idle
  assign ent_held   = tv_q & tm_q[TIMER_W];
  assign ent_timer  = tv_q ? tm_q[TIMER_W-1:0] : '0;
  assign key_is_mod = km_q[CODE_W];
  assign key_code   = km_q[CODE_W-1:0];
  assign in_range   = int'(k) < NUM_KEYS;

  // Decide the action for the current key
  always_comb begin
    act    = 1'b0;
    press  = 1'b0;
    expire = 1'b0;
    wdata  = '0;
    if (kind == FN_TICK) begin
      act    = 1'b1;
      expire = ent_timer == TIMER_FIRE;
      wdata  = expire ? '0 : {ent_held, ent_timer >> 1};
    end else begin
      act   = change[r] && in_range;
      press = act && cur[r] && !ent_held;
      wdata = cur[r] ? {1'b1, {TIMER_W{1'b0}}} : {ent_held, TIMER_ARM};
    end
    emit      = press || expire;
    go        = !(emit && pvalid) || out_ready;
    last_step = (kind == FN_TICK) ? (k == KEY_W'(NUM_KEYS - 1))
                                  : (r == ROW_IW'(NUM_ROWS - 1));
  end

  // Queue and modifier update for a press or release
  always_comb begin
    found = 1'b0;
    for (int i = 0; i < QUEUE_DEPTH; i++) begin
      q_ext[i] = queue[i];
      q_upd[i] = queue[i];
    end
    q_ext[QUEUE_DEPTH] = '0;
    mods_upd = mods;
    if (press) begin
      if (key_is_mod) begin
        mods_upd = mods | key_code;
      end else begin
        for (int i = 1; i < QUEUE_DEPTH; i++) begin
          q_upd[i] = queue[i-1];
        end
        q_upd[0] = '{vld: 1'b1, idx: k, code: key_code};
      end
    end else if (expire) begin
      if (key_is_mod) begin
        mods_upd = mods & ~key_code;
      end else begin
        for (int i = 0; i < QUEUE_DEPTH; i++) begin
          found = found || (queue[i].vld && queue[i].idx == k);
          if (found) begin
            q_upd[i] = q_ext[i+1];
          end
        end
      end
    end
  end

  // Build the report word, newest slot lowest
  for (genvar i = 0; i < NUM_SLOTS; i++) begin : g_slot
    if (i < QUEUE_DEPTH) begin : g_used
      assign rep_keys[i] = q_upd[i].vld ? q_upd[i].code : '0;
    end else begin : g_unused
      assign rep_keys[i] = '0;
    end
    assign rep_word[i*CODE_W +: CODE_W] = rep_keys[i];
  end
  assign rep_word[REP_W-1 -: CODE_W] = mods_upd;

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (cmd_valid && (cmd.kind == FN_SCAN || cmd.kind == FN_TICK)) begin
          state_next = ST_EXEC;
        end
      end
      ST_EXEC: begin
        if (go && last_step) begin
          state_next = ST_FLUSH;
        end
      end
      ST_FLUSH: begin
        if (!pvalid || out_ready) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // Outputs and counters
  always_comb begin
    cmd_pop  = 1'b0;
    k_next   = k;
    r_next   = r;
    rep.push = 1'b0;
    rep.last = 1'b0;
    rep.data = pdata;
    case (state)
      ST_IDLE: begin
        cmd_pop = cmd_valid;
        if (cmd_valid) begin
          r_next = '0;
          if (cmd.kind == FN_SCAN) begin
            k_next = KEY_W'(int'(cmd.column) * NUM_ROWS);
          end else begin
            k_next = '0;
          end
        end
      end
      ST_EXEC: begin
        rep.push = emit && pvalid && go;
        if (go && !last_step) begin
          k_next = k + 1'b1;
          r_next = r + 1'b1;
        end
      end
      ST_FLUSH: begin
        rep.push = pvalid && out_ready;
        rep.last = 1'b1;
      end
      default: ;
    endcase
  end

  // Memory reads follow the next key index
  always_ff @(posedge clk) begin
    km_q <= kmem[KAW'(k_next)];
    tm_q <= tmem[KAW'(k_next)];
    tv_q <= tvld[KAW'(k_next)];
  end

  // Memory writes
  always_ff @(posedge clk) begin
    if (state == ST_IDLE && cmd_valid && cmd.kind == FN_MAP) begin
      kmem[KAW'(cmd.key_index)] <= {cmd.is_mod, cmd.usage_code};
    end
    if (state == ST_EXEC && go && act) begin
      tmem[KAW'(k)] <= wdata;
    end
  end

  // Command registers
  always_ff @(posedge clk) begin
    k <= k_next;
    r <= r_next;
    if (cmd_pop) begin
      kind <= cmd.kind;
      cur  <= cmd.rows;
      change <= cmd.rows ^ prev[CAW'(cmd.column)];
    end
    if (state == ST_EXEC && go && emit) begin
      pdata <= rep_word;
    end
  end

  // Control state: sequencer, key state, queue, modifiers
  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= ST_IDLE;
      tvld   <= '0;
      mods   <= '0;
      pvalid <= 1'b0;
      for (int c = 0; c < NUM_COLS; c++) begin
        prev[c] <= '0;
      end
      for (int i = 0; i < QUEUE_DEPTH; i++) begin
        queue[i] <= '0;
      end
    end else begin
      state <= state_next;
      case (state)
        ST_IDLE: begin
          if (cmd_valid && cmd.kind == FN_SCAN) begin
            prev[CAW'(cmd.column)] <= cmd.rows;
          end
          // keep queued codes in step with the keymap
          if (cmd_valid && cmd.kind == FN_MAP) begin
            for (int i = 0; i < QUEUE_DEPTH; i++) begin
              if (queue[i].vld && queue[i].idx == cmd.key_index) begin
                queue[i].code <= cmd.usage_code;
              end
            end
          end
        end
        ST_EXEC: begin
          if (go && act) begin
            tvld[KAW'(k)] <= 1'b1;
          end
          if (go && emit) begin
            for (int i = 0; i < QUEUE_DEPTH; i++) begin
              queue[i] <= q_upd[i];
            end
            mods   <= mods_upd;
            pvalid <= 1'b1;
          end
        end
        ST_FLUSH: begin
          if (out_ready) begin
            pvalid <= 1'b0;
          end
        end
        default: ;
      endcase
    end
  end

endmodule

`default_nettype wire

/* hw/rtl/kmdr_out.sv */
// Output register for reports toward the stream receiver.
// Depends on kmdr_pkg; fed by kmdr_exec.
`default_nettype none

module kmdr_out
  import kmdr_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire rep_push_t   rep,
  output logic             ready,
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [REP_W-1:0] m_axis_tdata,  // key0 .. key5, modifiers
  output logic             m_axis_tlast   // last
);

  assign ready = !m_axis_tvalid || m_axis_tready;

  // Hold a report until the receiver takes it
  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (ready) begin
      m_axis_tvalid <= rep.push;
    end
  end

  always_ff @(posedge clk) begin
    if (ready && rep.push) begin
      m_axis_tdata <= rep.data;
      m_axis_tlast <= rep.last;
    end
  end

endmodule

`default_nettype wire

/* hw/rtl/key_matrix_debounce_rollover.sv */
// Keyboard matrix scanner with release debounce and six-key rollover.
// Input channel s_axis: tuser is the item kind (column scan, debounce tick,
// keymap write), tdata carries column, rows, key_index, usage_code, is_mod.
// Output channel m_axis: one report per press or release, tdata holds the
// six rollover slots (newest lowest) and the modifier byte; tlast marks the
// final report caused by an input item.
// Items pass a two-entry command queue to a sequencer that handles one item
// at a time. A keymap write is done in the idle state as it is popped; a scan
// or tick walks its rows or keys in the exec state, one key per cycle unless
// the output stalls (set by the single read port of the key state memory),
// then ends in the flush state. Each report is held one step so tlast can be
// set: it moves to the output register when the item's next report is made,
// or in the flush state for the final one. Items that do nothing (unused
// kind, column or key out of range) are taken and dropped at once.
// A report waits in the output register while the receiver stalls; the
// sequencer holds on the next report of the same item until it drains.
// Reset clears the row history, key state, rollover queue and modifiers;
// the keymap holds no defined value until written.
`default_nettype none

module key_matrix_debounce_rollover
  import kmdr_pkg::*;
#(
  parameter int NUM_COLS    = 8,
  parameter int NUM_ROWS    = 6,
  parameter int NUM_KEYS    = 48,
  parameter int QUEUE_DEPTH = 6
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             s_axis_tvalid,
  output logic                  s_axis_tready,
  input  wire logic [IN_W-1:0]  s_axis_tdata,  // column, rows, key_index, usage_code, is_mod
  input  wire logic [1:0]       s_axis_tuser,  // func
  output logic                  m_axis_tvalid,
  input  wire logic             m_axis_tready,
  output logic [REP_W-1:0]      m_axis_tdata,  // key0, key1, key2, key3, key4, key5, modifiers
  output logic                  m_axis_tlast   // last
);

  cmd_t      front_cmd;
  cmd_t      head_cmd;
  logic      front_push;
  logic      fifo_full;
  logic      fifo_valid;
  logic      fifo_pop;
  logic      out_ready;
  rep_push_t rep;

  kmdr_front #(
    .NUM_COLS (NUM_COLS),
    .NUM_KEYS (NUM_KEYS)
  ) u_front (
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .fifo_full     (fifo_full),
    .push          (front_push),
    .cmd           (front_cmd)
  );

  kmdr_cmd_fifo u_fifo (
    .clk   (clk),
    .rst   (rst),
    .push  (front_push),
    .din   (front_cmd),
    .full  (fifo_full),
    .valid (fifo_valid),
    .head  (head_cmd),
    .pop   (fifo_pop)
  );

  kmdr_exec #(
    .NUM_COLS    (NUM_COLS),
    .NUM_ROWS    (NUM_ROWS),
    .NUM_KEYS    (NUM_KEYS),
    .QUEUE_DEPTH (QUEUE_DEPTH)
  ) u_exec (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (fifo_valid),
    .cmd       (head_cmd),
    .cmd_pop   (fifo_pop),
    .out_ready (out_ready),
    .rep       (rep)
  );

  kmdr_out u_out (
    .clk           (clk),
    .rst           (rst),
    .rep           (rep),
    .ready         (out_ready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
  );

endmodule

`default_nettype wire

/* tb/tb_top.sv */
// Self-checking testbench for key_matrix_debounce_rollover.
// Drives scan, tick and keymap items over the input stream and predicts each
// report from its own copy of the scanner state; depends on kmdr_pkg.
`default_nettype none

module tb_top;
  import kmdr_pkg::*;

  localparam int N_COLS      = 8;
  localparam int N_ROWS      = 6;
  localparam int N_KEYS      = 48;
  localparam int WATCH_LIMIT = 5000;
  localparam int DRAIN_WAIT  = 200;

  // Item kind the block must drop
  localparam logic [1:0] FN_UNUSED = 2'd3;

  typedef struct packed {
    logic                        last;
    logic [CODE_W-1:0]           mods;
    logic [NUM_SLOTS*CODE_W-1:0] slots;
  } report_t;

  logic clk;
  logic rst;
  logic s_axis_tvalid;
  logic s_axis_tready;
  logic [IN_W-1:0] s_axis_tdata;   // column, rows, key_index, usage_code, is_mod
  logic [1:0] s_axis_tuser;        // func
  logic m_axis_tvalid;
  logic m_axis_tready;
  logic [REP_W-1:0] m_axis_tdata;  // key0, key1, key2, key3, key4, key5, modifiers
  logic m_axis_tlast;              // last

  key_matrix_debounce_rollover #(
    .NUM_COLS   (N_COLS),
    .NUM_ROWS   (N_ROWS),
    .NUM_KEYS   (N_KEYS),
    .QUEUE_DEPTH(NUM_SLOTS)
  ) dut (
    .clk          (clk),
    .rst          (rst),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tlast (m_axis_tlast)
  );

  // Scanner state as the testbench sees it
  logic [ROW_W-1:0]   col_seen  [N_COLS];
  logic               key_down  [N_KEYS];
  logic [TIMER_W-1:0] key_timer [N_KEYS];
  logic [KEY_W-1:0]   roll_key  [NUM_SLOTS];
  logic               roll_vld  [NUM_SLOTS];
  logic [CODE_W-1:0]  mod_bits;
  logic [CODE_W-1:0]  map_code  [N_KEYS];
  logic               map_mod   [N_KEYS];

  report_t report_q[$];
  report_t staged;
  bit      staged_vld;
  int      mismatches;
  bit      tx_idle_en;
  bit      rx_idle_en;
  bit      rx_on;
  int      rx_left;
  int      quiet_cycles;

  always #5 clk = ~clk;

  // Snapshot the rollover slots and modifiers; hold the newest one back so the
  // final report of an item can get its last flag
  task automatic stage_report();
    report_t r;
    int i;
    r.last = 1'b0;
    r.mods = mod_bits;
    for (i = 0; i < NUM_SLOTS; i++) begin
      r.slots[i*CODE_W +: CODE_W] = roll_vld[i] ? map_code[roll_key[i]] : 8'h00;
    end
    if (staged_vld) begin
      report_q.push_back(staged);
    end
    staged = r;
    staged_vld = 1'b1;
  endtask

  task automatic press_key(input int k);
    int i;
    key_down[k] = 1'b1;
    key_timer[k] = '0;
    if (map_mod[k]) begin
      mod_bits = mod_bits | map_code[k];
    end else begin
      for (i = NUM_SLOTS - 1; i > 0; i--) begin
        roll_key[i] = roll_key[i-1];
        roll_vld[i] = roll_vld[i-1];
      end
      roll_key[0] = k[KEY_W-1:0];
      roll_vld[0] = 1'b1;
    end
    stage_report();
  endtask

  task automatic release_key(input int k);
    int i;
    int found;
    key_down[k] = 1'b0;
    key_timer[k] = '0;
    if (map_mod[k]) begin
      mod_bits = mod_bits & ~map_code[k];
    end else begin
      found = NUM_SLOTS;
      for (i = 0; i < NUM_SLOTS; i++) begin
        if (found == NUM_SLOTS && roll_vld[i] && roll_key[i] == k[KEY_W-1:0]) found = i;
      end
      // Close the gap and empty the oldest slot
      if (found < NUM_SLOTS) begin
        for (i = found; i < NUM_SLOTS - 1; i++) begin
          roll_key[i] = roll_key[i+1];
          roll_vld[i] = roll_vld[i+1];
        end
        roll_key[NUM_SLOTS-1] = '0;
        roll_vld[NUM_SLOTS-1] = 1'b0;
      end
    end
    stage_report();
  endtask

  // Advance the scanner state by one accepted item and queue its reports
  task automatic predict_item(input cmd_t it);
    logic [ROW_W-1:0] changed;
    int row;
    int k;
    case (it.kind)
      FN_SCAN: begin
        changed = it.rows ^ col_seen[it.column];
        for (row = 0; row < N_ROWS; row++) begin
          k = int'(it.column) * N_ROWS + row;
          if (changed[row] && k < N_KEYS) begin
            if (it.rows[row]) begin
              if (!key_down[k]) press_key(k);
              else key_timer[k] = '0;
            end else begin
              key_timer[k] = TIMER_ARM;
            end
          end
        end
        col_seen[it.column] = it.rows;
      end
      FN_TICK: begin
        for (k = 0; k < N_KEYS; k++) begin
          if (key_timer[k] == TIMER_FIRE) release_key(k);
          key_timer[k] = key_timer[k] >> 1;
        end
      end
      FN_MAP: begin
        if (it.key_index < N_KEYS) begin
          map_code[it.key_index] = it.usage_code;
          map_mod[it.key_index] = it.is_mod;
        end
      end
      default: ;
    endcase
    if (staged_vld) begin
      staged.last = 1'b1;
      report_q.push_back(staged);
      staged_vld = 1'b0;
    end
  endtask

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (!tx_idle_en || r < 50) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Offer one item, hold it until taken, then predict its reports
  task automatic send_item(input cmd_t it);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= {it.is_mod, it.usage_code, it.key_index, it.rows, it.column};
    s_axis_tuser <= it.kind;
    do @(posedge clk); while (!s_axis_tready);
    predict_item(it);
  endtask

  function automatic cmd_t scan_cmd(input logic [COL_W-1:0] c, input logic [ROW_W-1:0] r);
    cmd_t it;
    it = '0;
    it.kind = FN_SCAN;
    it.column = c;
    it.rows = r;
    return it;
  endfunction

  function automatic cmd_t tick_cmd();
    cmd_t it;
    it = '0;
    it.kind = FN_TICK;
    return it;
  endfunction

  function automatic cmd_t map_cmd(input logic [KEY_W-1:0] k, input logic [CODE_W-1:0] code,
                                   input logic is_mod);
    cmd_t it;
    it = '0;
    it.kind = FN_MAP;
    it.key_index = k;
    it.usage_code = code;
    it.is_mod = is_mod;
    return it;
  endfunction

  task automatic note_mismatch(input string what, input logic [63:0] want,
                               input logic [63:0] got);
    mismatches++;
    if (mismatches <= 10) begin
      $display("mismatch %s: expected %0h, got %0h", what, want, got);
    end
  endtask

  // Compare one taken report with the oldest prediction
  task automatic check_report(input logic [REP_W-1:0] data, input logic lst);
    report_t want;
    int i;
    if (report_q.size() == 0) begin
      note_mismatch("report with none pending", '0, 64'({lst, data}));
    end else begin
      want = report_q.pop_front();
      for (i = 0; i < NUM_SLOTS; i++) begin
        if (data[i*CODE_W +: CODE_W] !== want.slots[i*CODE_W +: CODE_W]) begin
          note_mismatch($sformatf("key%0d", i), 64'(want.slots[i*CODE_W +: CODE_W]),
                        64'(data[i*CODE_W +: CODE_W]));
        end
      end
      if (data[REP_W-1 -: CODE_W] !== want.mods) begin
        note_mismatch("modifiers", 64'(want.mods), 64'(data[REP_W-1 -: CODE_W]));
      end
      if (lst !== want.last) begin
        note_mismatch("last", 64'(want.last), 64'(lst));
      end
    end
  endtask

  // Take reports and pace the receiver
  always @(posedge clk) begin
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      check_report(m_axis_tdata, m_axis_tlast);
    end
    if (rx_left == 0) begin
      if (!rx_idle_en || $urandom_range(0, 9) < 6) begin
        rx_on = 1'b1;
        rx_left = $urandom_range(1, 20);
      end else begin
        rx_on = 1'b0;
        rx_left = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40) : $urandom_range(1, 3);
      end
    end else begin
      rx_left--;
    end
    m_axis_tready <= rx_on;
  end

  // End the run when nothing moves on either side for too long
  always @(posedge clk) begin
    if (rst || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= WATCH_LIMIT) begin
        $display("end of test: mismatches");
        $finish;
      end
    end
  end

  // Load every keymap entry; every fifth key is a modifier
  task automatic test_keymap_load();
    int k;
    logic [CODE_W-1:0] code;
    for (k = 0; k < N_KEYS; k++) begin
      if (k % 5 == 3) code = 8'h01 << (k % 8);
      else code = CODE_W'($urandom_range(0, 255));
      if (k == 0) code = 8'h00;
      if (k == 1 || k == 43) code = 8'hFF;
      if (k == 2) code = 8'h01;
      send_item(map_cmd(k[KEY_W-1:0], code, k % 5 == 3));
    end
  endtask

  // Drop out-of-range keymap writes and the unused kind
  task automatic test_ignored_items();
    cmd_t it;
    send_item(map_cmd(6'd63, 8'hFF, 1'b1));
    send_item(map_cmd(6'd48, 8'h5A, 1'b0));
    it = '1;
    it.kind = func_t'(FN_UNUSED);
    send_item(it);
  endtask

  // Press two full columns so the rollover queue overflows
  task automatic test_press_rollover();
    send_item(scan_cmd(3'd0, 6'h3F));
    send_item(scan_cmd(3'd7, 6'h3F));
  endtask

  // Open keys, cancel one by closing it again, and let the timers expire;
  // some released keys have already fallen out of the queue
  task automatic test_release_debounce();
    send_item(scan_cmd(3'd0, 6'h00));
    send_item(scan_cmd(3'd0, 6'h01));
    send_item(scan_cmd(3'd7, 6'h00));
    repeat (8) send_item(tick_cmd());
    send_item(scan_cmd(3'd0, 6'h00));
    repeat (8) send_item(tick_cmd());
  endtask

  // Mostly single-key presses and releases with ticks; some noise
  task automatic test_random_traffic(input int n_items, input bit tx_idle, input bit rx_idle);
    cmd_t it;
    int done;
    int r;
    logic [COL_W-1:0] c;
    tx_idle_en = tx_idle;
    rx_idle_en = rx_idle;
    done = 0;
    while (done < n_items) begin
      r = $urandom_range(0, 99);
      if (r < 55) begin
        c = COL_W'($urandom_range(0, N_COLS - 1));
        if ($urandom_range(0, 3) == 0) it = scan_cmd(c, ROW_W'($urandom_range(0, 63)));
        else it = scan_cmd(c, col_seen[c] ^ (6'b1 << $urandom_range(0, N_ROWS - 1)));
        done++;
      end else if (r < 88) begin
        it = tick_cmd();
        done++;
      end else if (r < 96) begin
        it = map_cmd(KEY_W'($urandom_range(0, 63)), CODE_W'($urandom_range(0, 255)),
                     $urandom_range(0, 3) == 0);
        if (it.key_index < N_KEYS) done++;
      end else begin
        it = cmd_t'(($bits(cmd_t))'($urandom));
        it.kind = func_t'(FN_UNUSED);
      end
      send_item(it);
    end
  endtask

  initial begin
    clk = 1'b0;
    rst = 1'b1;
    s_axis_tvalid = 1'b0;
    s_axis_tdata = '0;
    s_axis_tuser = '0;
    m_axis_tready = 1'b0;
    mismatches = 0;
    rx_left = 0;
    rx_on = 1'b0;
    quiet_cycles = 0;
    staged_vld = 1'b0;
    tx_idle_en = 1'b1;
    rx_idle_en = 1'b1;
    mod_bits = '0;
    for (int i = 0; i < N_COLS; i++) col_seen[i] = '0;
    for (int i = 0; i < N_KEYS; i++) begin
      key_down[i] = 1'b0;
      key_timer[i] = '0;
      map_code[i] = '0;
      map_mod[i] = 1'b0;
    end
    for (int i = 0; i < NUM_SLOTS; i++) begin
      roll_key[i] = '0;
      roll_vld[i] = 1'b0;
    end

    repeat (10) @(posedge clk);
    rst <= 1'b0;

    test_keymap_load();
    test_ignored_items();
    test_press_rollover();
    test_release_debounce();
    test_random_traffic(140, 1'b1, 1'b1);
    test_random_traffic(70, 1'b0, 1'b0);
    test_random_traffic(70, 1'b1, 1'b0);
    test_random_traffic(70, 1'b0, 1'b1);
    s_axis_tvalid <= 1'b0;

    // Drain pending reports, then watch for strays
    while (report_q.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
    if (mismatches == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

`default_nettype wire
